[rtl/hfe_pkg.sv]
// Package with the shared constants, command codes and types of the Huffman encoder.
package hfe_pkg;

  // Table geometry and code limits.
  localparam int NUM_SYMBOLS   = 256;
  localparam int MAX_CODE_LEN  = 32;
  localparam int TABLE_DEPTH   = 256;
  localparam int CODE_W        = 32;
  localparam int LEN_W         = 6;
  localparam int ENTRY_W       = CODE_W + LEN_W;
  localparam int ACC_W         = CODE_W + 7;
  localparam int MAX_RESULTS   = 4;

  // Stored lengths saturate to the smaller of the code limit and the field width.
  localparam logic [LEN_W-1:0] LEN_CAP =
    (MAX_CODE_LEN < CODE_W) ? LEN_W'(MAX_CODE_LEN) : LEN_W'(CODE_W);

  // Symbols at or above this limit are ignored.
  localparam logic [8:0] SYM_LIMIT = 9'(NUM_SYMBOLS);

  // Command codes of an input word.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // Work held in the lookup stage.
  typedef enum logic {
    KIND_ENCODE,
    KIND_FLUSH
  } hfe_kind_t;

  // One code table entry: saturated length over the right-aligned code word.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
  } hfe_entry_t;

  // Request from the lookup stage to the bit packer.
  typedef struct packed {
    logic      valid;
    hfe_kind_t kind;
  } hfe_req_t;

endpackage

[rtl/hfe_if.sv]
// Valid/ready channel interfaces for the encoder's input and result words.
interface hfe_in_if;
  import hfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [7:0]        symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_len;

  modport source (output valid, cmd, symbol, code_bits, code_len, input ready);
  modport sink   (input valid, cmd, symbol, code_bits, code_len, output ready);
endinterface

interface hfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

[rtl/huffman_encoder_core.sv]
// Top level of the Huffman encoder: code table, lookup stage and bit packer.
//
//   Channel   Direction  Word contents
//   in_word   sink       cmd, symbol, code_bits, code_len
//   out_word  source     out_byte, last_of_run
//
// A word is accepted in any cycle in which the lookup stage is empty or moving on.
// A load writes the table RAM at its accept edge; an encode reads the RAM at that edge,
// is packed once the byte buffer is free and offers its first byte after the edge that ends it.
// An encode of n bytes (up to four) holds the single-byte result port until the last is taken;
// later byte-emitting words wait, but an encode or flush that emits nothing moves on at once.
// Reset clears the pending bits, the lookup stage and the byte buffer, but not the table.
module huffman_encoder_core (
  input  logic      clk,
  input  logic      rst_n,
  hfe_in_if.sink    in_word,
  hfe_out_if.source out_word
);
  import hfe_pkg::*;

  logic       accept;
  logic       sym_ok;
  logic       go;
  logic       s1_valid_r, s1_valid_nxt;
  hfe_kind_t  s1_kind_r, s1_kind_nxt;
  logic [LEN_W-1:0] sat_len;
  hfe_entry_t wr_entry;
  hfe_entry_t rd_entry;
  hfe_req_t   req;

  // Input handshake and command decode.
  always_comb begin
    in_word.ready = !s1_valid_r || go;
    accept        = in_word.valid && in_word.ready;
    sym_ok        = ({1'b0, in_word.symbol} < SYM_LIMIT);
    sat_len       = (in_word.code_len > LEN_CAP) ? LEN_CAP : in_word.code_len;
    wr_entry.len  = sat_len;
    wr_entry.bits = in_word.code_bits;
  end

  // Code table.
  hfe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (accept && (in_word.cmd == CMD_LOAD) && sym_ok),
    .waddr (in_word.symbol),
    .wdata (wr_entry),
    .re    (accept && (in_word.cmd == CMD_ENCODE)),
    .raddr (in_word.symbol),
    .rdata (rd_entry)
  );

  // Lookup stage: holds an encode or flush while the table data is read.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_kind_nxt  = s1_kind_r;
    if (go) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = ((in_word.cmd == CMD_ENCODE) && sym_ok) || (in_word.cmd == CMD_FLUSH);
      s1_kind_nxt  = (in_word.cmd == CMD_FLUSH) ? KIND_FLUSH : KIND_ENCODE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r <= s1_kind_nxt;
  end

  always_comb begin
    req.valid = s1_valid_r;
    req.kind  = s1_kind_r;
  end

  // Bit packer and result emitter.
  hfe_packer u_packer (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .entry    (rd_entry),
    .go       (go),
    .out_word (out_word)
  );

  // An accepted encode or flush always lands in the lookup stage.
  a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (((in_word.cmd == CMD_ENCODE) && sym_ok) || (in_word.cmd == CMD_FLUSH))
    |=> s1_valid_r)
    else $error("encode or flush word did not enter the lookup stage");

  // A stalled lookup stage keeps its work.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !go |=> s1_valid_r && $stable(s1_kind_r))
    else $error("stalled lookup stage lost its word");

  // The input stalls only while a result word waits on the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_word.ready |-> s1_valid_r && out_word.valid)
    else $error("input stalled with no result word pending");

endmodule

[rtl/hfe_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module hfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/hfe_packer.sv]
// MSB-first bit packer: pending partial byte, byte buffer and output word emitter.
module hfe_packer (
  input  logic              clk,
  input  logic              rst_n,
  input  hfe_pkg::hfe_req_t req,
  input  hfe_pkg::hfe_entry_t entry,
  output logic              go,
  hfe_out_if.source         out_word
);
  import hfe_pkg::*;

  logic [6:0]       partial_r, partial_nxt;
  logic [2:0]       pend_r, pend_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [5:0]       tot_r, tot_nxt;
  logic [2:0]       cnt_r, cnt_nxt;

  logic [CODE_W:0]   mask_wide;
  logic [CODE_W-1:0] code;
  logic [ACC_W-1:0]  acc;
  logic [5:0]        total;
  logic [7:0]        flush_byte;
  logic [7:0]        low_mask;
  logic [2:0]        nbytes;
  logic              buf_free;
  logic              out_acc;
  logic [5:0]        shamt;
  logic [ACC_W-1:0]  shifted;

  // Append the masked code word to the pending bits.
  always_comb begin
    mask_wide  = ((CODE_W+1)'(1) << entry.len) - (CODE_W+1)'(1);
    code       = entry.bits & mask_wide[CODE_W-1:0];
    acc        = ({{CODE_W{1'b0}}, partial_r} << entry.len) | {7'd0, code};
    total      = {3'd0, pend_r} + entry.len;
    flush_byte = {1'b0, partial_r} << (4'd8 - {1'b0, pend_r});
    low_mask   = (8'd1 << total[2:0]) - 8'd1;
  end

  // Count the words this request emits and decide whether it can move on.
  always_comb begin
    unique case (req.kind)
      KIND_ENCODE: nbytes = (entry.len == '0) ? 3'd0 : total[5:3];
      KIND_FLUSH:  nbytes = (pend_r != 3'd0) ? 3'd1 : 3'd0;
      default:     nbytes = 3'd0;
    endcase
    out_acc  = out_word.valid && out_word.ready;
    buf_free = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_word.ready);
    go       = req.valid && ((nbytes == 3'd0) || buf_free);
  end

  // Next pending bits and next buffer contents.
  always_comb begin
    partial_nxt = partial_r;
    pend_nxt    = pend_r;
    acc_nxt     = acc_r;
    tot_nxt     = tot_r;
    cnt_nxt     = cnt_r;
    if (out_acc) begin
      cnt_nxt = cnt_r - 3'd1;
      tot_nxt = tot_r - 6'd8;
    end
    if (go) begin
      unique case (req.kind)
        KIND_ENCODE: begin
          if (entry.len != '0) begin
            partial_nxt = acc[6:0] & low_mask[6:0];
            pend_nxt    = total[2:0];
          end
          if (nbytes != 3'd0) begin
            acc_nxt = acc;
            tot_nxt = total;
            cnt_nxt = nbytes;
          end
        end
        KIND_FLUSH: begin
          partial_nxt = 7'd0;
          pend_nxt    = 3'd0;
          if (nbytes != 3'd0) begin
            acc_nxt = {{(ACC_W-8){1'b0}}, flush_byte};
            tot_nxt = 6'd8;
            cnt_nxt = 3'd1;
          end
        end
        default: begin
          pend_nxt = pend_r;
        end
      endcase
    end
  end

  // Control state and pending bits reset; the buffer payload needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 7'd0;
      pend_r    <= 3'd0;
      cnt_r     <= 3'd0;
    end else begin
      partial_r <= partial_nxt;
      pend_r    <= pend_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    tot_r <= tot_nxt;
  end

  // Emit the oldest buffered byte, most significant bits first.
  always_comb begin
    shamt                = tot_r - 6'd8;
    shifted              = acc_r >> shamt;
    out_word.valid       = (cnt_r != 3'd0);
    out_word.out_byte    = shifted[7:0];
    out_word.last_of_run = (cnt_r == 3'd1);
  end

endmodule
